[src/assert_macros.svh]
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at each rising clock edge, ignored while reset is low.
`define ASSERT_CHK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Check a property at each rising clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

[src/pga_pkg.sv]
`default_nettype none
package pga_pkg;

  localparam int SAMPLE_W     = 16;
  localparam int PROD_W       = 2 * SAMPLE_W;
  localparam int ACC_W        = PROD_W + 1;
  localparam int CORD_W       = ACC_W + 3;
  localparam int TURN_W       = 32;
  localparam int ANGLE_W      = 16;
  localparam int CORDIC_STEPS = 16;
  localparam int STEP_W       = $clog2(CORDIC_STEPS);
  localparam int COUNT_W      = 12;
  localparam int TAG_W        = 32;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [COUNT_W-1:0] PAIR_CAP  = {COUNT_W{1'b1}};
  localparam logic [TURN_W-1:0]  HALF_TURN = {1'b1, {(TURN_W-1){1'b0}}};
  localparam logic [TURN_W-1:0]  ROUND_ADD = {{(ANGLE_W){1'b0}}, 1'b1, {(TURN_W-ANGLE_W-1){1'b0}}};

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_BAD_TAG     = 2'd1,
    ST_BAD_PROFILE = 2'd2,
    ST_FEW_PAIRS   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    MUL_RR,
    MUL_II,
    MUL_RI,
    MUL_IR
  } mul_sel_t;

  typedef enum logic [2:0] {
    ACC_NONE,
    ACC_RE_LOAD,
    ACC_RE_ADD,
    ACC_IM_LOAD,
    ACC_IM_SUB
  } acc_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL0,
    S_MUL1,
    S_MUL2,
    S_MUL3,
    S_MACC,
    S_CINIT,
    S_CORD,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic              load;
    logic              mul_en;
    mul_sel_t          mul_sel;
    acc_op_t           acc_op;
    logic              cord_init;
    logic              cord_step;
    logic [STEP_W-1:0] cord_idx;
    logic              commit;
  } cmd_t;

  typedef struct packed {
    logic pair_ok;
    logic out_free;
  } sts_t;

  // atan(2^-i) in full-turn units, 2^32 being one turn
  function automatic logic [TURN_W-1:0] atan_turns(input logic [STEP_W-1:0] idx);
    logic [TURN_W-1:0] v;
    case (idx)
      4'd0:    v = 32'h20000000;
      4'd1:    v = 32'h12E4051E;
      4'd2:    v = 32'h09FB385B;
      4'd3:    v = 32'h051111D4;
      4'd4:    v = 32'h028B0D43;
      4'd5:    v = 32'h0145D7E1;
      4'd6:    v = 32'h00A2F61E;
      4'd7:    v = 32'h00517C55;
      4'd8:    v = 32'h0028BE53;
      4'd9:    v = 32'h00145F2F;
      4'd10:   v = 32'h000A2F98;
      4'd11:   v = 32'h000517CC;
      4'd12:   v = 32'h00028BE6;
      4'd13:   v = 32'h000145F3;
      4'd14:   v = 32'h0000A2FA;
      4'd15:   v = 32'h0000517D;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

[src/pga_cordic.sv]
`default_nettype none
module pga_cordic (
  input  wire                             clk,
  input  wire                             init,
  input  wire                             step,
  input  wire  [pga_pkg::STEP_W-1:0]      idx,
  input  wire  signed [pga_pkg::ACC_W-1:0] re,
  input  wire  signed [pga_pkg::ACC_W-1:0] im,
  output logic [pga_pkg::TURN_W-1:0]      z
);
  import pga_pkg::*;

  logic signed [CORD_W-1:0] x_r, x_nxt;
  logic signed [CORD_W-1:0] y_r, y_nxt;
  logic        [TURN_W-1:0] z_r, z_nxt;
  logic signed [CORD_W-1:0] xe, ye, dx, dy;
  logic                     y_pos;

  always_comb begin
    xe    = {{(CORD_W-ACC_W){re[ACC_W-1]}}, re};
    ye    = {{(CORD_W-ACC_W){im[ACC_W-1]}}, im};
    dx    = y_r >>> idx;
    dy    = x_r >>> idx;
    y_pos = !y_r[CORD_W-1] && (y_r != '0);
    x_nxt = x_r;
    y_nxt = y_r;
    z_nxt = z_r;
    if (init) begin
      // fold the left half plane onto the right one
      if (xe[CORD_W-1]) begin
        x_nxt = -xe;
        y_nxt = -ye;
        z_nxt = HALF_TURN;
      end else begin
        x_nxt = xe;
        y_nxt = ye;
        z_nxt = '0;
      end
    end else if (step) begin
      if (y_pos) begin
        x_nxt = x_r + dx;
        y_nxt = y_r - dy;
        z_nxt = z_r + atan_turns(idx);
      end else begin
        x_nxt = x_r - dx;
        y_nxt = y_r + dy;
        z_nxt = z_r - atan_turns(idx);
      end
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
  end

  assign z = z_r;

endmodule
`default_nettype wire

[src/pga_ctrl.sv]
`default_nettype none
module pga_ctrl (
  input  wire           clk,
  input  wire           rst_n,
  input  wire           in_tvalid,
  output logic          in_tready,
  input  pga_pkg::sts_t sts,
  output pga_pkg::cmd_t cmd
);
  import pga_pkg::*;

  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      S_IDLE:   if (in_tvalid) state_nxt = sts.pair_ok ? S_MUL0 : S_FINISH;
      S_MUL0:   state_nxt = S_MUL1;
      S_MUL1:   state_nxt = S_MUL2;
      S_MUL2:   state_nxt = S_MUL3;
      S_MUL3:   state_nxt = S_MACC;
      S_MACC:   state_nxt = S_CINIT;
      S_CINIT: begin
        state_nxt = S_CORD;
        cnt_nxt   = '0;
      end
      S_CORD: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LAST_STEP) state_nxt = S_FINISH;
      end
      S_FINISH: if (sts.out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.mul_sel  = MUL_RR;
    cmd.acc_op   = ACC_NONE;
    cmd.cord_idx = cnt_r;
    in_tready    = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      S_MUL0: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_RR;
      end
      S_MUL1: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_II;
        cmd.acc_op  = ACC_RE_LOAD;
      end
      S_MUL2: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_RI;
        cmd.acc_op  = ACC_RE_ADD;
      end
      S_MUL3: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_IR;
        cmd.acc_op  = ACC_IM_LOAD;
      end
      S_MACC:   cmd.acc_op = ACC_IM_SUB;
      S_CINIT:  cmd.cord_init = 1'b1;
      S_CORD:   cmd.cord_step = 1'b1;
      S_FINISH: cmd.commit = sts.out_free;
      default:  cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

[src/pga_dp.sv]
`default_nettype none
module pga_dp (
  input  wire                                clk,
  input  wire                                rst_n,
  input  pga_pkg::cmd_t                      cmd,
  output pga_pkg::sts_t                      sts,
  input  wire  [pga_pkg::TAG_W-1:0]          in_tag,
  input  wire  signed [pga_pkg::SAMPLE_W-1:0] in_real,
  input  wire  signed [pga_pkg::SAMPLE_W-1:0] in_imag,
  input  wire                                in_sup,
  input  wire                                in_last,
  input  wire                                cfg_we,
  input  wire  [pga_pkg::COUNT_W-1:0]        cfg_data,
  input  wire                                out_tready,
  output logic                               out_tvalid,
  output logic [pga_pkg::TAG_W-1:0]          out_tag,
  output logic [pga_pkg::COUNT_W-1:0]        out_index,
  output logic [pga_pkg::ANGLE_W-1:0]        out_grad,
  output logic                               out_pvalid,
  output logic                               out_last,
  output pga_pkg::status_t                   out_status,
  output logic [pga_pkg::COUNT_W-1:0]        out_vtotal
);
  import pga_pkg::*;

  // current item
  logic        [TAG_W-1:0]    cur_tag_r;
  logic signed [SAMPLE_W-1:0] cur_real_r, cur_imag_r;
  logic                       cur_sup_r, cur_last_r, pair_ok_r;
  // profile state
  logic signed [SAMPLE_W-1:0] prev_real_r, prev_imag_r;
  logic                       prev_sup_r, have_prev_r;
  logic        [COUNT_W-1:0]  pair_cnt_r, valid_cnt_r, min_pairs_r;
  logic        [TAG_W-1:0]    held_tag_r;
  // complex product
  logic signed [SAMPLE_W-1:0] ma, mb;
  logic signed [PROD_W-1:0]   prod_r, prod_nxt;
  logic signed [ACC_W-1:0]    re_r, re_nxt, im_r, im_nxt;
  // commit values
  logic [TURN_W-1:0]  z, z_rnd;
  logic [TAG_W-1:0]   tag_eff;
  logic [COUNT_W-1:0] pc_base, vc_base, pc_new, vc_new;
  logic               pair_ok_now, emit;
  status_t            status;
  // output register
  logic                out_valid_r;
  logic [TAG_W-1:0]    out_tag_r;
  logic [COUNT_W-1:0]  out_index_r, out_vtotal_r;
  logic [ANGLE_W-1:0]  out_grad_r;
  logic                out_pvalid_r, out_last_r;
  status_t             out_status_r;

  assign pair_ok_now = have_prev_r && prev_sup_r && in_sup &&
                       ((prev_real_r != '0) || (prev_imag_r != '0)) &&
                       ((in_real != '0) || (in_imag != '0));
  assign sts.pair_ok  = pair_ok_now;
  assign sts.out_free = !out_valid_r || out_tready || !emit;

  always_comb begin
    case (cmd.mul_sel)
      MUL_RR:  begin ma = prev_real_r; mb = cur_real_r; end
      MUL_II:  begin ma = prev_imag_r; mb = cur_imag_r; end
      MUL_RI:  begin ma = prev_real_r; mb = cur_imag_r; end
      MUL_IR:  begin ma = prev_imag_r; mb = cur_real_r; end
      default: begin ma = prev_real_r; mb = cur_real_r; end
    endcase
    prod_nxt = cmd.mul_en ? ma * mb : prod_r;
    re_nxt   = re_r;
    im_nxt   = im_r;
    case (cmd.acc_op)
      ACC_RE_LOAD: re_nxt = ACC_W'(prod_r);
      ACC_RE_ADD:  re_nxt = re_r + ACC_W'(prod_r);
      ACC_IM_LOAD: im_nxt = ACC_W'(prod_r);
      ACC_IM_SUB:  im_nxt = im_r - ACC_W'(prod_r);
      default:     ;
    endcase
  end

  pga_cordic u_cordic (
    .clk  (clk),
    .init (cmd.cord_init),
    .step (cmd.cord_step),
    .idx  (cmd.cord_idx),
    .re   (re_r),
    .im   (im_r),
    .z    (z)
  );

  always_comb begin
    z_rnd   = z + ROUND_ADD;
    tag_eff = have_prev_r ? held_tag_r : cur_tag_r;
    pc_base = have_prev_r ? pair_cnt_r : '0;
    vc_base = have_prev_r ? valid_cnt_r : '0;
    vc_new  = (pair_ok_r && (vc_base != COUNT_MAX)) ? vc_base + 1'b1 : vc_base;
    pc_new  = (have_prev_r && (pc_base != PAIR_CAP)) ? pc_base + 1'b1 : pc_base;
    emit    = have_prev_r || cur_last_r;
    status  = ST_OK;
    if (cur_last_r) begin
      if (tag_eff == '0)                          status = ST_BAD_TAG;
      else if (!have_prev_r || min_pairs_r == '0) status = ST_BAD_PROFILE;
      else if (vc_new < min_pairs_r)              status = ST_FEW_PAIRS;
      else                                        status = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    re_r   <= re_nxt;
    im_r   <= im_nxt;
    if (cmd.load) begin
      cur_tag_r  <= in_tag;
      cur_real_r <= in_real;
      cur_imag_r <= in_imag;
      cur_sup_r  <= in_sup;
      cur_last_r <= in_last;
      pair_ok_r  <= pair_ok_now;
    end
    if (cmd.commit && emit) begin
      out_tag_r    <= tag_eff;
      out_index_r  <= pc_base;
      out_grad_r   <= pair_ok_r ? z_rnd[TURN_W-1 -: ANGLE_W] : '0;
      out_pvalid_r <= pair_ok_r;
      out_last_r   <= cur_last_r;
      out_status_r <= status;
      out_vtotal_r <= vc_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_pairs_r <= COUNT_W'(1);
      prev_real_r <= '0;
      prev_imag_r <= '0;
      prev_sup_r  <= 1'b0;
      have_prev_r <= 1'b0;
      pair_cnt_r  <= '0;
      valid_cnt_r <= '0;
      held_tag_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) min_pairs_r <= cfg_data;
      if (cmd.commit) begin
        held_tag_r <= tag_eff;
        if (cur_last_r) begin
          prev_real_r <= '0;
          prev_imag_r <= '0;
          prev_sup_r  <= 1'b0;
          have_prev_r <= 1'b0;
          pair_cnt_r  <= '0;
          valid_cnt_r <= '0;
        end else begin
          prev_real_r <= cur_real_r;
          prev_imag_r <= cur_imag_r;
          prev_sup_r  <= cur_sup_r;
          have_prev_r <= 1'b1;
          pair_cnt_r  <= pc_new;
          valid_cnt_r <= vc_new;
        end
      end
      if (cmd.commit && emit) out_valid_r <= 1'b1;
      else if (out_tready)    out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tag    = out_tag_r;
  assign out_index  = out_index_r;
  assign out_grad   = out_grad_r;
  assign out_pvalid = out_pvalid_r;
  assign out_last   = out_last_r;
  assign out_status = out_status_r;
  assign out_vtotal = out_vtotal_r;

endmodule
`default_nettype wire

[src/pga_phase_gradient_estimator_top.sv]
// Phase gradient estimator for autofocus. Feed one complex aperture sample
// per item, a profile at a time, with tlast on its final sample. Each sample
// after the first yields one result for the pair (previous, current): the
// angle of conj(previous) * current in 16-bit turn units (32768 is pi, pi
// itself shows as -32768), or zero with pair_valid low when either sample is
// unsupported or zero. The result of the last sample carries tlast and the
// profile status. The request tag is taken from the first sample only.
// A valid pair runs states MUL0 to MUL3 and MACC, where one shared 16x16
// multiplier forms the four partial products of the complex product, then
// CINIT and a single CORDIC stage running 16 iterations; any other sample
// goes from IDLE straight to FINISH. A held output stalls the block only
// when its next result is ready. min_valid_pairs is written through cfg_
// and may only be changed while the block is idle; it resets to 1.
`default_nettype none
module pga_phase_gradient_estimator_top (
  input  wire         clk,
  input  wire         rst_n,
  // in_tdata: request_tag[31:0], sample_real[47:32], sample_imag[63:48]
  input  wire  [63:0] in_tdata,
  // in_tuser: supported
  input  wire         in_tuser,
  input  wire         in_tlast,
  input  wire         in_tvalid,
  output logic        in_tready,
  // out_tdata: result_tag[31:0], pair_index[43:32], gradient[59:44],
  //            valid_pair_total[71:60]
  output logic [71:0] out_tdata,
  // out_tuser: pair_valid[0], status[2:1]
  output logic [2:0]  out_tuser,
  output logic        out_tlast,
  output logic        out_tvalid,
  input  wire         out_tready,
  // cfg_data: min_valid_pairs
  input  wire  [11:0] cfg_data,
  input  wire         cfg_valid,
  output logic        cfg_ready
);
  import pga_pkg::*;

  cmd_t               cmd;
  sts_t               sts;
  logic [TAG_W-1:0]   res_tag;
  logic [COUNT_W-1:0] res_index, res_vtotal;
  logic [ANGLE_W-1:0] res_grad;
  logic               res_pvalid;
  status_t            res_status;

  // the register write never stalls
  assign cfg_ready = 1'b1;

  pga_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  pga_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tag     (in_tdata[31:0]),
    .in_real    (in_tdata[47:32]),
    .in_imag    (in_tdata[63:48]),
    .in_sup     (in_tuser),
    .in_last    (in_tlast),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_data   (cfg_data),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tag    (res_tag),
    .out_index  (res_index),
    .out_grad   (res_grad),
    .out_pvalid (res_pvalid),
    .out_last   (out_tlast),
    .out_status (res_status),
    .out_vtotal (res_vtotal)
  );

  // pack the result fields, lowest field first
  assign out_tdata = {res_vtotal, res_grad, res_index, res_tag};
  assign out_tuser = {res_status, res_pvalid};

endmodule
`default_nettype wire

[src/pga_checker.sv]
`default_nettype none
`include "assert_macros.svh"
module pga_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        in_tvalid,
  input wire        in_tready,
  input wire [71:0] out_tdata,
  input wire [2:0]  out_tuser,
  input wire        out_tlast,
  input wire        out_tvalid,
  input wire        out_tready
);

  logic [76:0] out_bus;

  assign out_bus = {out_tvalid, out_tlast, out_tuser, out_tdata};

  // a held result keeps its content
  `ASSERT_CHK(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> $stable(out_bus))

  // the block is busy in the cycle after it accepts an item
  `ASSERT_CHK(a_busy_after_accept, clk, rst_n, in_tvalid && in_tready |=> !in_tready)

  // status is only reported on the profile's last result
  `ASSERT_CHK(a_status_end_only, clk, rst_n, out_tvalid && !out_tlast |-> out_tuser[2:1] == 2'd0)

  // an invalid pair carries a zero gradient
  `ASSERT_CHK(a_grad_zero, clk, rst_n, out_tvalid && !out_tuser[0] |-> out_tdata[59:44] == 16'd0)

  // reset empties the output register
  `ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_tvalid)

endmodule

bind pga_phase_gradient_estimator_top pga_checker u_pga_checker (.*);
`default_nettype wire

[dv/tb_pga_phase_gradient_estimator_top.sv]
`timescale 1ns / 1ps
module tb_pga_phase_gradient_estimator_top;
  import pga_pkg::*;

  localparam int CYCLE_LIMIT    = 1500000;
  localparam int SETTLE_CYCLES  = 64;
  localparam int HOLDOFF_CYCLES = 400;
  localparam int LONG_PROFILE   = 100;

  typedef struct packed {
    logic [31:0]        tag;
    logic signed [15:0] re;
    logic signed [15:0] im;
    logic               sup;
    logic               last;
  } sample_t;

  typedef struct packed {
    logic [31:0]        tag;
    logic [11:0]        idx;
    logic signed [15:0] grad;
    logic               valid;
    logic               eop;
    status_t            status;
    logic [11:0]        total;
  } grad_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic [63:0] in_tdata   = '0;
  logic        in_tuser   = 1'b0;
  logic        in_tlast   = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [71:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [11:0] cfg_data   = '0;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;

  pga_phase_gradient_estimator_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_data   (cfg_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // atan(2^-i) in 32-bit full-turn units
  logic [31:0] atan_lut [16] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
  };

  // Expected profile state and register copy
  logic [11:0]        min_pairs = 12'd1;
  logic signed [15:0] prev_re   = '0;
  logic signed [15:0] prev_im   = '0;
  logic               prev_sup  = 1'b0;
  logic               have_prev = 1'b0;
  logic [11:0]        pair_cnt  = '0;
  logic [11:0]        valid_cnt = '0;
  logic [31:0]        held_tag  = '0;

  sample_t samples_to_send[$];
  grad_t   grads_expected[$];

  int n_queued, n_accepted, n_results, n_profiles, n_fail, n_cfg_writes, cycle_count;
  int holdoffs_asked, holdoffs_done;
  bit idle_on = 1'b1;

  // Vectoring CORDIC on the pair product, rounded to 16-bit turn units
  function automatic logic [15:0] pair_angle(input longint x, input longint y);
    logic [31:0] z;
    longint      dx, dy;
    int          i;
    z = '0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = HALF_TURN;
    end
    for (i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx;
        y -= dy;
        z += atan_lut[i];
      end else begin
        x -= dx;
        y += dy;
        z -= atan_lut[i];
      end
    end
    z = z + 32'h0000_8000;
    return z[31:16];
  endfunction

  // Advance the expected profile state by one accepted sample
  task automatic track_sample(input sample_t s);
    grad_t  r;
    logic   had;
    longint pr, pi;
    had      = have_prev;
    r        = '0;
    r.status = ST_OK;
    if (!had) begin
      held_tag  = s.tag;
      pair_cnt  = '0;
      valid_cnt = '0;
    end else begin
      r.idx   = pair_cnt;
      r.valid = prev_sup && s.sup && (prev_re != 0 || prev_im != 0) &&
                (s.re != 0 || s.im != 0);
      if (r.valid) begin
        pr     = longint'(prev_re) * longint'(s.re) + longint'(prev_im) * longint'(s.im);
        pi     = longint'(prev_re) * longint'(s.im) - longint'(prev_im) * longint'(s.re);
        r.grad = pair_angle(pr, pi);
        if (valid_cnt != COUNT_MAX) valid_cnt++;
      end
      if (pair_cnt != PAIR_CAP) pair_cnt++;
    end
    if (!had && !s.last) begin
      prev_re   = s.re;
      prev_im   = s.im;
      prev_sup  = s.sup;
      have_prev = 1'b1;
      return;
    end
    if (s.last) begin
      if (held_tag == 0) r.status = ST_BAD_TAG;
      else if (!had || min_pairs == 0) r.status = ST_BAD_PROFILE;
      else if (valid_cnt < min_pairs) r.status = ST_FEW_PAIRS;
    end
    r.tag   = held_tag;
    r.eop   = s.last;
    r.total = valid_cnt;
    grads_expected.push_back(r);
    if (s.last) begin
      prev_re   = '0;
      prev_im   = '0;
      prev_sup  = 1'b0;
      have_prev = 1'b0;
      pair_cnt  = '0;
      valid_cnt = '0;
    end else begin
      prev_re   = s.re;
      prev_im   = s.im;
      prev_sup  = s.sup;
      have_prev = 1'b1;
    end
  endtask

  // Sender: offer queued samples, hold until taken, idle in random bursts
  sample_t on_bus;
  bit      in_took;
  int      in_gap;

  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_took) begin
      if (in_gap > 0) begin
        in_gap--;
        in_tvalid <= 1'b0;
      end else if (samples_to_send.size() > 0) begin
        on_bus = samples_to_send.pop_front();
        in_tdata  <= {on_bus.im, on_bus.re, on_bus.tag};
        in_tuser  <= on_bus.sup;
        in_tlast  <= on_bus.last;
        in_tvalid <= 1'b1;
        if (idle_on && $urandom_range(0, 3) == 0) in_gap = $urandom_range(1, 11);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: stall in random bursts, or hold off for a long stretch on request
  int hold_left, stall_left;

  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (holdoffs_done < holdoffs_asked) begin
      holdoffs_done++;
      hold_left = HOLDOFF_CYCLES - 1;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 10);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Monitor: predict on each accepted sample, check each accepted result
  always @(posedge clk) begin
    grad_t got, want;
    in_took = 1'b0;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        in_took = 1'b1;
        n_accepted++;
        track_sample(on_bus);
      end
      if (out_tvalid && out_tready) begin
        got.tag    = out_tdata[31:0];
        got.idx    = out_tdata[43:32];
        got.grad   = out_tdata[59:44];
        got.total  = out_tdata[71:60];
        got.valid  = out_tuser[0];
        got.status = status_t'(out_tuser[2:1]);
        got.eop    = out_tlast;
        n_results++;
        if (got.eop) n_profiles++;
        if (grads_expected.size() == 0) begin
          if (n_fail < 10)
            $display("%0t: unexpected result tag=%h idx=%0d grad=%0d valid=%b eop=%b st=%0d tot=%0d",
                     $time, got.tag, got.idx, got.grad, got.valid, got.eop, got.status,
                     got.total);
          n_fail++;
        end else begin
          want = grads_expected.pop_front();
          if (got !== want) begin
            if (n_fail < 10) begin
              $display("%0t: mismatch exp tag=%h idx=%0d grad=%0d valid=%b eop=%b st=%0d tot=%0d",
                       $time, want.tag, want.idx, want.grad, want.valid, want.eop, want.status,
                       want.total);
              $display("%0t:          got tag=%h idx=%0d grad=%0d valid=%b eop=%b st=%0d tot=%0d",
                       $time, got.tag, got.idx, got.grad, got.valid, got.eop, got.status,
                       got.total);
            end
            n_fail++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               grads_expected.size());
      $display("pga_phase_gradient_estimator_top regression: fail");
      $finish;
    end
  end

  task automatic queue_sample(input logic [31:0] tag, input logic [15:0] re,
                              input logic [15:0] im, input logic sup, input logic last);
    sample_t s;
    s.tag  = tag;
    s.re   = re;
    s.im   = im;
    s.sup  = sup;
    s.last = last;
    samples_to_send.push_back(s);
    n_queued++;
  endtask

  // Mix of zero, full-scale, tiny and arbitrary component values
  function automatic logic [15:0] rand_comp();
    case ($urandom_range(0, 9))
      0:       return 16'h0000;
      1:       return 16'h8000;
      2:       return 16'h7FFF;
      3, 4:    return 16'($urandom_range(0, 15) - 8);
      default: return 16'($urandom);
    endcase
  endfunction

  // Clean profiles keep most pairs valid; noisy ones drop support and zero samples freely
  task automatic queue_profile(input int len, input bit noisy);
    logic [31:0] tag;
    logic [15:0] re, im;
    logic        sup;
    tag = ($urandom_range(0, 15) == 0) ? 32'd0 : $urandom;
    for (int k = 0; k < len; k++) begin
      re = rand_comp();
      im = rand_comp();
      if (noisy) begin
        sup = 1'($urandom_range(0, 1));
      end else begin
        sup = ($urandom_range(0, 15) != 0);
        if (re == 0 && im == 0) re = 16'd1;
      end
      queue_sample((k == 0) ? tag : $urandom, re, im, sup, k == len - 1);
    end
  endtask

  task automatic queue_random(input int n_items);
    int left, len;
    left = n_items;
    while (left > 0) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 12);
      if (len > left) len = left;
      queue_profile(len, $urandom_range(0, 4) == 0);
      left -= len;
    end
  endtask

  task automatic write_min_pairs(input logic [11:0] v);
    @(negedge clk);
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    min_pairs = v;
    n_cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Wait for every queued sample to be taken and every result to come back
  task automatic wait_idle();
    @(negedge clk);
    while (n_accepted != n_queued || grads_expected.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    logic [15:0] re, im;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    write_min_pairs(12'd1);
    // lone last sample: zero tag, then a good tag
    queue_sample(32'd0, 16'd5, 16'd5, 1'b1, 1'b1);
    queue_sample(32'hFFFF_FFFF, 16'h8000, 16'h7FFF, 1'b1, 1'b1);
    // full-scale corners and the pi wrap; tags after the first are ignored
    queue_sample(32'h8000_0001, 16'd1, 16'd0, 1'b1, 1'b0);
    queue_sample(32'd0, 16'hFFFF, 16'd0, 1'b1, 1'b0);
    queue_sample(32'h0000_1234, 16'h8000, 16'h8000, 1'b1, 1'b0);
    queue_sample(32'h5555_AAAA, 16'h7FFF, 16'h7FFF, 1'b1, 1'b0);
    queue_sample(32'h0, 16'h8000, 16'h7FFF, 1'b1, 1'b0);
    queue_sample(32'h1, 16'h7FFF, 16'h8000, 1'b1, 1'b0);
    queue_sample(32'h2, 16'h0000, 16'h0000, 1'b1, 1'b0);
    queue_sample(32'h3, 16'd3, 16'd4, 1'b1, 1'b0);
    queue_sample(32'h4, 16'd4, 16'hFFFD, 1'b0, 1'b0);
    queue_sample(32'h5, 16'd0, 16'h8000, 1'b1, 1'b0);
    queue_sample(32'h6, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0);
    queue_sample(32'h7, 16'hFFFF, 16'h0001, 1'b1, 1'b1);
    // zero tag despite good pairs
    queue_sample(32'd0, 16'd100, 16'd200, 1'b1, 1'b0);
    queue_sample(32'h0000_ABCD, 16'd200, 16'd100, 1'b1, 1'b0);
    queue_sample(32'h0000_ABCD, 16'hFFCE, 16'd60, 1'b1, 1'b1);
    // no valid pair at all: too few pairs
    queue_sample(32'd1, 16'd7, 16'd7, 1'b0, 1'b0);
    queue_sample(32'd1, 16'd7, 16'hFFF9, 1'b1, 1'b0);
    queue_sample(32'd1, 16'd0, 16'd0, 1'b1, 1'b1);
    wait_idle();

    // zero minimum marks every profile invalid
    write_min_pairs(12'd0);
    queue_random(150);
    wait_idle();

    // long all-valid profile against the largest minimum
    write_min_pairs(12'hFFF);
    for (int k = 0; k < LONG_PROFILE; k++) begin
      re = rand_comp();
      im = rand_comp();
      if (re == 0 && im == 0) im = 16'h8000;
      queue_sample((k == 0) ? 32'hC0DE_0001 : $urandom, re, im, 1'b1, k == LONG_PROFILE - 1);
    end
    wait_idle();

    // long receiver hold-off while the sender keeps offering
    write_min_pairs(12'd3);
    queue_random(500);
    holdoffs_asked++;
    wait_idle();

    write_min_pairs(12'($urandom_range(1, 4095)));
    queue_random(200);
    wait_idle();

    write_min_pairs(12'd2);
    queue_random(400);
    wait_idle();

    // final stretch at full rate
    idle_on = 1'b0;
    write_min_pairs(12'd1);
    queue_random(350);
    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d samples in %0d profiles, %0d results checked, %0d register writes",
             n_accepted, n_profiles, n_results, n_cfg_writes);
    $display("mismatches %0d, results outstanding %0d", n_fail, grads_expected.size());
    if (n_fail == 0 && grads_expected.size() == 0) begin
      $display("pga_phase_gradient_estimator_top regression: pass");
    end else begin
      $display("pga_phase_gradient_estimator_top regression: fail");
    end
    $finish;
  end

endmodule
